>>> rtl/lpfx_pkg.sv
package lpfx_pkg;

	localparam int PIXEL_COUNT_DEF = 18;

	// effect modes
	localparam logic [2:0] MODE_OFF    = 3'd0;
	localparam logic [2:0] MODE_ON     = 3'd1;
	localparam logic [2:0] MODE_SLOW   = 3'd2;
	localparam logic [2:0] MODE_FAST   = 3'd3;
	localparam logic [2:0] MODE_RANDOM = 3'd7;
	localparam logic [3:0] MODE_MAX    = 4'd7;

	localparam logic [3:0] COLOUR_RAINBOW = 4'd10;

	localparam logic [15:0] LFSR_TAPS = 16'hB400;

	// register indexes on the config port
	localparam logic [2:0] REG_FAST_ON  = 3'd0;
	localparam logic [2:0] REG_FAST_END = 3'd1;
	localparam logic [2:0] REG_SLOW_ON  = 3'd2;
	localparam logic [2:0] REG_SLOW_END = 3'd3;
	localparam logic [2:0] REG_SEED     = 3'd4;

	localparam logic [7:0]  FAST_ON_RST  = 8'd20;
	localparam logic [7:0]  FAST_END_RST = 8'd40;
	localparam logic [7:0]  SLOW_ON_RST  = 8'd40;
	localparam logic [7:0]  SLOW_END_RST = 8'd80;
	localparam logic [15:0] SEED_RST     = 16'd1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SET,
		ST_TICK
	} state_t;

	// one pixel entry; shown is r,g,b,w from msb down
	typedef struct packed {
		logic [2:0]  mode;
		logic [3:0]  colour;
		logic [7:0]  count;
		logic [31:0] shown;
	} entry_t;

	function automatic logic [31:0] fixed_colour(input logic [3:0] c);
		logic [31:0] v;
		case (c)
			4'd0: v = 32'hF0F000FF;
			4'd1: v = 32'hFFFFFFFF;
			4'd2: v = 32'h000000FF;
			4'd3: v = 32'hFF000000;
			4'd4: v = 32'h00FF0000;
			4'd5: v = 32'hFF5A0000;
			4'd6: v = 32'h0000FF00;
			4'd7: v = 32'hFFFF0000;
			4'd8: v = 32'h00FFFF00;
			4'd9: v = 32'hFF00FF00;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

	// 255-step colour wheel
	function automatic logic [31:0] colour_wheel(input logic [7:0] pos);
		logic [7:0] p;
		logic [7:0] q;
		logic [7:0] t;
		logic [31:0] v;
		p = 8'd255 - pos;
		if (p < 8'd85) begin
			t = 8'(p * 2'd3);
			v = {8'd255 - t, 8'd0, t, 8'd0};
		end else if (p < 8'd170) begin
			q = p - 8'd85;
			t = 8'(q * 2'd3);
			v = {8'd0, t, 8'd255 - t, 8'd0};
		end else begin
			q = p - 8'd170;
			t = 8'(q * 2'd3);
			v = {t, 8'd255 - t, 8'd0, 8'd0};
		end
		return v;
	endfunction

	function automatic logic [15:0] lfsr_step(input logic [15:0] x);
		logic [15:0] y;
		y = x >> 1;
		if (x[0]) begin
			y = y ^ LFSR_TAPS;
		end
		return y;
	endfunction

endpackage

>>> rtl/led_pixel_effect_engine_unit.sv
// Per-pixel RGBW effect engine.
// Input channel (in_valid/in_stall): op=0 is a set word that stores colour and
// mode of one pixel; it is dropped when pixel, colour or mode is out of range
// and never yields an output word. op=1 is a tick: every pixel is walked from
// 0 to PIXEL_COUNT-1 and one output word per pixel goes out on the output
// channel (out_valid/out_stall), last marking the final pixel.
// The pixel table sits in one synchronous RAM (one entry per pixel). A tick
// takes one pixel per cycle, while the output is not stalled, through read,
// update and write-back: each updated entry goes into the registered output
// word, one word per cycle while the output takes them, and the next input
// word is taken once the walk is done. A set reads, then writes back.
// A stall on the output freezes the walk; the held word stays put, and
// in_stall stays high until the tick's walk is done.
// Reset: config registers go to their defaults, the twinkle LFSR to the seed,
// and per-entry valid flops make every pixel read as off and dark, so no
// clearing pass is needed.
// Config is an APB-style port, registers at byte address 4*index; pready is
// tied high. Writing the seed also reloads the LFSR (zero loads as one).
module led_pixel_effect_engine_unit import lpfx_pkg::*; #(
	parameter int PIXEL_COUNT = PIXEL_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// input words
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [4:0]  pixel,
	input  logic [3:0]  colour,
	input  logic [3:0]  mode,
	// output words
	output logic        out_valid,
	input  logic        out_stall,
	output logic [4:0]  out_pixel,
	output logic [7:0]  red,
	output logic [7:0]  green,
	output logic [7:0]  blue,
	output logic [7:0]  white,
	output logic        last,
	// config
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int IDX_W = (PIXEL_COUNT > 1) ? $clog2(PIXEL_COUNT) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

	// config registers
	logic [7:0]  fast_on_q, fast_end_q, slow_on_q, slow_end_q;
	logic [15:0] seed_q;
	logic [15:0] lfsr_q;
	logic        cfg_wr;
	logic [2:0]  cfg_idx;

	// control
	state_t           state_q, state_nxt;
	logic [IDX_W-1:0] idx_q;
	logic [3:0]       set_colour_q;
	logic [2:0]       set_mode_q;
	logic             in_acc;
	logic             set_ok;
	logic             adv;
	logic             wr_en;
	entry_t           wr_data;
	logic [IDX_W-1:0] rd_addr;

	// pixel table RAM plus valid flops
	entry_t                 mem [PIXEL_COUNT];
	logic [PIXEL_COUNT-1:0] valid_q;
	entry_t                 rd_s1;
	logic                   rdv_s1;
	entry_t                 cur;

	// tick datapath
	entry_t      upd;
	logic [7:0]  n;
	logic        show_req;
	logic [15:0] x1, x2;
	logic [23:0] r_prod;
	logic [7:0]  r_draw;
	logic [15:0] lfsr_nxt;

	// output register
	logic        out_valid_q;
	logic [4:0]  out_pixel_q;
	logic [31:0] out_rgbw_q;
	logic        out_last_q;

	//--------------------------------------------------------------
	// config port
	assign pready  = 1'b1;
	assign cfg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_comb begin
		case (cfg_idx)
			REG_FAST_ON:  prdata = {24'd0, fast_on_q};
			REG_FAST_END: prdata = {24'd0, fast_end_q};
			REG_SLOW_ON:  prdata = {24'd0, slow_on_q};
			REG_SLOW_END: prdata = {24'd0, slow_end_q};
			REG_SEED:     prdata = {16'd0, seed_q};
			default:      prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_on_q  <= FAST_ON_RST;
			fast_end_q <= FAST_END_RST;
			slow_on_q  <= SLOW_ON_RST;
			slow_end_q <= SLOW_END_RST;
			seed_q     <= SEED_RST;
			lfsr_q     <= SEED_RST;
		end else begin
			if (cfg_wr) begin
				case (cfg_idx)
					REG_FAST_ON:  fast_on_q  <= pwdata[7:0];
					REG_FAST_END: fast_end_q <= pwdata[7:0];
					REG_SLOW_ON:  slow_on_q  <= pwdata[7:0];
					REG_SLOW_END: slow_end_q <= pwdata[7:0];
					REG_SEED: begin
						seed_q <= pwdata[15:0];
						lfsr_q <= (pwdata[15:0] == 16'd0) ? 16'd1 : pwdata[15:0];
					end
					default: ;
				endcase
			end else if (adv) begin
				lfsr_q <= lfsr_nxt;
			end
		end
	end

	//--------------------------------------------------------------
	// sequencer
	assign in_acc = in_valid & ~in_stall;
	assign set_ok = (32'(pixel) < PIXEL_COUNT) && (colour <= COLOUR_RAINBOW)
		&& (mode <= MODE_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_stall  = 1'b1;
		adv       = 1'b0;
		wr_en     = 1'b0;
		wr_data   = upd;
		rd_addr   = idx_q;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (op) begin
						rd_addr   = '0;
						state_nxt = ST_TICK;
					end else begin
						rd_addr = IDX_W'(pixel);
						if (set_ok) begin
							state_nxt = ST_SET;
						end
					end
				end
			end
			ST_SET: begin
				// count restarts only when the mode really changes
				wr_en          = 1'b1;
				wr_data        = cur;
				wr_data.colour = set_colour_q;
				wr_data.mode   = set_mode_q;
				if (cur.mode != set_mode_q) begin
					wr_data.count = 8'd0;
				end
				state_nxt = ST_IDLE;
			end
			ST_TICK: begin
				if (!out_valid_q || !out_stall) begin
					adv   = 1'b1;
					wr_en = 1'b1;
					if (idx_q == LAST_IDX) begin
						state_nxt = ST_IDLE;
					end else begin
						rd_addr = idx_q + 1'b1;
					end
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (in_acc) begin
			idx_q <= op ? '0 : IDX_W'(pixel);
		end else if (adv && idx_q != LAST_IDX) begin
			idx_q <= idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			set_colour_q <= colour;
			set_mode_q   <= mode[2:0];
		end
	end

	//--------------------------------------------------------------
	// pixel table
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx_q] <= wr_data;
		end
		rd_s1 <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rdv_s1  <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[idx_q] <= 1'b1;
			end
			rdv_s1 <= valid_q[rd_addr];
		end
	end

	// never-written entry reads as off, dark
	assign cur = rdv_s1 ? rd_s1 : '0;

	//--------------------------------------------------------------
	// per-pixel effect update
	assign x1     = lfsr_step(lfsr_q);
	assign x2     = lfsr_step(x1);
	assign r_prod = {x1, 8'd0} - 24'(x1);
	assign r_draw = r_prod[23:16];

	always_comb begin
		upd       = cur;
		n         = cur.count + 8'd1;
		upd.count = n;
		show_req  = 1'b0;
		lfsr_nxt  = lfsr_q;
		case (cur.mode)
			MODE_OFF: upd.shown = 32'd0;
			MODE_ON:  show_req = 1'b1;
			MODE_SLOW, MODE_FAST: begin
				if (n < ((cur.mode == MODE_SLOW) ? slow_on_q : fast_on_q)) begin
					show_req = 1'b1;
				end else if (n < ((cur.mode == MODE_SLOW) ? slow_end_q : fast_end_q)) begin
					upd.shown = 32'd0;
				end else begin
					upd.count = 8'd0;
				end
			end
			MODE_RANDOM: begin
				lfsr_nxt = x1;
				if (r_draw > n) begin
					lfsr_nxt = x2;
					if (!x2[0]) begin
						show_req = 1'b1;
					end else begin
						upd.shown = 32'd0;
					end
				end
			end
			default: ; // fade and breath hold the colour
		endcase
		if (show_req) begin
			if (cur.colour == COLOUR_RAINBOW) begin
				upd.shown = colour_wheel(n);
				upd.count = n + 8'd1;
			end else if (cur.colour < COLOUR_RAINBOW) begin
				upd.shown = fixed_colour(cur.colour);
			end
		end
	end

	//--------------------------------------------------------------
	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_pixel_q <= 5'(idx_q);
			out_rgbw_q  <= upd.shown;
			out_last_q  <= (idx_q == LAST_IDX);
		end
	end

	assign out_valid = out_valid_q;
	assign out_pixel = out_pixel_q;
	assign red       = out_rgbw_q[31:24];
	assign green     = out_rgbw_q[23:16];
	assign blue      = out_rgbw_q[15:8];
	assign white     = out_rgbw_q[7:0];
	assign last      = out_last_q;

	//--------------------------------------------------------------
	// checks
	a_lfsr_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		lfsr_q != 16'd0)
		else $error("twinkle LFSR reached zero");

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (32'(idx_q) < PIXEL_COUNT))
		else $error("table write beyond pixel count");

	a_set_goes_wb: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && !op && set_ok) |=> (state_q == ST_SET))
		else $error("valid set did not reach write-back");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TICK && adv && idx_q == LAST_IDX)
		|=> (out_valid_q && out_last_q && state_q == ST_IDLE))
		else $error("tick walk did not end with last word");

	a_out_from_tick: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_TICK))
		else $error("output word raised outside tick walk");

endmodule

>>> tb/led_pixel_effect_engine_unit_tb.sv
`timescale 1ns / 100ps

module led_pixel_effect_engine_unit_tb;
	import lpfx_pkg::*;

	localparam int CLK_PERIOD    = 12;
	localparam int RESET_CYCLES  = 11;
	localparam int PIXELS        = PIXEL_COUNT_DEF;
	localparam int MAX_IDLE      = 12;
	// a tick walks every pixel, a set reads then writes back; margin on top
	localparam int SETTLE_CYCLES = PIXELS + 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int STALL_LIMIT   = 4000;

	// input word codes
	localparam logic OP_SET  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [3:0] FX_OFF       = {1'b0, MODE_OFF};
	localparam logic [3:0] FX_ON        = {1'b0, MODE_ON};
	localparam logic [3:0] FX_SLOW      = {1'b0, MODE_SLOW};
	localparam logic [3:0] FX_FAST      = {1'b0, MODE_FAST};
	localparam logic [3:0] FX_FADE_UP   = 4'd4;
	localparam logic [3:0] FX_FADE_DOWN = 4'd5;
	localparam logic [3:0] FX_BREATH    = 4'd6;
	localparam logic [3:0] FX_RANDOM    = {1'b0, MODE_RANDOM};
	localparam logic [3:0] FX_FIRST_BAD = MODE_MAX + 4'd1;

	localparam logic [3:0] COL_WARM_WHITE = 4'd0;
	localparam logic [3:0] COL_COOL_WHITE = 4'd1;
	localparam logic [3:0] COL_PURE_WHITE = 4'd2;
	localparam logic [3:0] COL_RED        = 4'd3;
	localparam logic [3:0] COL_GREEN      = 4'd4;
	localparam logic [3:0] COL_AMBER      = 4'd5;
	localparam logic [3:0] COL_BLUE       = 4'd6;
	localparam logic [3:0] COL_YELLOW     = 4'd7;
	localparam logic [3:0] COL_CYAN       = 4'd8;
	localparam logic [3:0] COL_MAGENTA    = 4'd9;
	localparam logic [3:0] COL_FIRST_BAD  = COLOUR_RAINBOW + 4'd1;
	localparam logic [3:0] FIELD4_MAX     = 4'hF;

	// register index with nothing behind it
	localparam logic [2:0] REG_UNUSED = 3'd5;

	// fixed palette, packed r,g,b,w from msb down
	localparam logic [31:0] PALETTE [10] = '{
		32'hF0F000FF, 32'hFFFFFFFF, 32'h000000FF, 32'hFF000000, 32'h00FF0000,
		32'hFF5A0000, 32'h0000FF00, 32'hFFFF0000, 32'h00FFFF00, 32'hFF00FF00
	};

	localparam logic [PIXELS-1:0] NO_PIXELS  = '0;
	localparam logic [PIXELS-1:0] END_PIXELS = {1'b1, {(PIXELS-2){1'b0}}, 1'b1};
	localparam logic [31:0]       DARK       = 32'h0;
	localparam logic [31:0]       COOL_RGBW  = 32'hFFFFFFFF;

	typedef struct packed {
		logic [4:0] px;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] white;
		logic       last;
	} pixel_word_t;

	// directed row; where typed is set the frame is given here, not predicted:
	// pixels in lit_mask show lit_rgbw, all others are dark
	typedef struct packed {
		logic              o;
		logic [4:0]        px;
		logic [3:0]        cl;
		logic [3:0]        md;
		logic              typed;
		logic [PIXELS-1:0] lit_mask;
		logic [31:0]       lit_rgbw;
	} script_row_t;

	localparam int DIRECTED_ROWS = 25;
	localparam script_row_t SCRIPT [DIRECTED_ROWS] = '{
		// out of reset every pixel is off and dark
		'{OP_TICK, 5'd0,  COL_WARM_WHITE, FX_OFF,       1'b1, NO_PIXELS,  DARK},
		// both end pixels steady on
		'{OP_SET,  5'd0,  COL_COOL_WHITE, FX_ON,        1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd17, COL_COOL_WHITE, FX_ON,        1'b0, NO_PIXELS,  DARK},
		'{OP_TICK, 5'd0,  COL_WARM_WHITE, FX_OFF,       1'b1, END_PIXELS, COOL_RGBW},
		// out-of-range sets, all dropped
		'{OP_SET,  5'd18, COL_RED,        FX_ON,        1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd31, COL_RED,        FX_ON,        1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd0,  COL_FIRST_BAD,  FX_ON,        1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd0,  FIELD4_MAX,     FX_ON,        1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd0,  COL_RED,        FX_FIRST_BAD, 1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd17, COL_RED,        FIELD4_MAX,   1'b0, NO_PIXELS,  DARK},
		// tick with junk in the set fields: frame unchanged
		'{OP_TICK, 5'd31, FIELD4_MAX,     FIELD4_MAX,   1'b1, END_PIXELS, COOL_RGBW},
		// at least one pixel per effect
		'{OP_SET,  5'd1,  COLOUR_RAINBOW, FX_ON,        1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd2,  COL_AMBER,      FX_SLOW,      1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd3,  COL_BLUE,       FX_FAST,      1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd4,  COL_YELLOW,     FX_FADE_UP,   1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd5,  COL_CYAN,       FX_FADE_DOWN, 1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd6,  COL_MAGENTA,    FX_BREATH,    1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd7,  COLOUR_RAINBOW, FX_RANDOM,    1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd8,  COL_PURE_WHITE, FX_RANDOM,    1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd9,  COL_GREEN,      FX_FAST,      1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd0,  COL_COOL_WHITE, FX_OFF,       1'b0, NO_PIXELS,  DARK},
		'{OP_TICK, 5'd0,  COL_WARM_WHITE, FX_OFF,       1'b0, NO_PIXELS,  DARK},
		// same mode keeps the count, a new mode clears it
		'{OP_SET,  5'd3,  COL_BLUE,       FX_FAST,      1'b0, NO_PIXELS,  DARK},
		'{OP_SET,  5'd9,  COL_GREEN,      FX_SLOW,      1'b0, NO_PIXELS,  DARK},
		'{OP_TICK, 5'd0,  COL_WARM_WHITE, FX_OFF,       1'b0, NO_PIXELS,  DARK}
	};

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        op;
	logic [4:0]  pixel;
	logic [3:0]  colour;
	logic [3:0]  mode;
	logic        out_valid;
	logic        out_stall;
	logic [4:0]  out_pixel;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  white;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	always #(CLK_PERIOD / 2) clk = ~clk;

	led_pixel_effect_engine_unit #(
		.PIXEL_COUNT(PIXELS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.pixel(pixel),
		.colour(colour),
		.mode(mode),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_pixel(out_pixel),
		.red(red),
		.green(green),
		.blue(blue),
		.white(white),
		.last(last),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// ------------------------------------------------------------------
	// Effect predictor: own copy of the pixel table, LFSR and registers
	// ------------------------------------------------------------------
	logic [2:0]  mode_of   [PIXELS];
	logic [3:0]  colour_of [PIXELS];
	logic [7:0]  count_of  [PIXELS];
	logic [31:0] shown_of  [PIXELS];
	logic [15:0] twinkle;
	logic [15:0] reg_file  [5];

	// frame worked out by the last tick
	pixel_word_t frame_buf [PIXELS];
	// words still owed by the block, oldest first
	pixel_word_t pending_pixels [$];

	int mismatches = 0;
	bit no_gaps    = 1'b0;	// both sides run back to back
	bit hold_req   = 1'b0;	// ask the output side for one long stall

	function automatic void reset_effects();
		for (int i = 0; i < PIXELS; i++) begin
			mode_of[i]   = MODE_OFF;
			colour_of[i] = COL_WARM_WHITE;
			count_of[i]  = 8'd0;
			shown_of[i]  = DARK;
		end
		reg_file[REG_FAST_ON]  = {8'd0, FAST_ON_RST};
		reg_file[REG_FAST_END] = {8'd0, FAST_END_RST};
		reg_file[REG_SLOW_ON]  = {8'd0, SLOW_ON_RST};
		reg_file[REG_SLOW_END] = {8'd0, SLOW_END_RST};
		reg_file[REG_SEED]     = SEED_RST;
		twinkle                = SEED_RST;
	endfunction

	function automatic void store_register(input logic [2:0] idx, input logic [31:0] value);
		case (idx)
			REG_FAST_ON, REG_FAST_END, REG_SLOW_ON, REG_SLOW_END: begin
				reg_file[idx] = {8'd0, value[7:0]};
			end
			REG_SEED: begin
				reg_file[REG_SEED] = value[15:0];
				// zero seed would lock the LFSR up
				twinkle = (value[15:0] == 16'd0) ? 16'd1 : value[15:0];
			end
			default: ;
		endcase
	endfunction

	// color wheel: thirds red->blue, blue->green, green->red as pos falls
	function automatic logic [31:0] wheel_rgbw(input logic [7:0] pos);
		logic [7:0] p;
		logic [7:0] k;
		logic [7:0] up;
		logic [7:0] dn;
		p = 8'd255 - pos;
		if (p < 8'd85) begin
			k = p;
		end else if (p < 8'd170) begin
			k = p - 8'd85;
		end else begin
			k = p - 8'd170;
		end
		up = k + k + k;
		dn = 8'd255 - up;
		if (p < 8'd85) begin
			return {dn, 8'd0, up, 8'd0};
		end else if (p < 8'd170) begin
			return {8'd0, up, dn, 8'd0};
		end
		return {up, dn, 8'd0, 8'd0};
	endfunction

	function automatic void twinkle_step();
		twinkle = {1'b0, twinkle[15:1]} ^ (twinkle[0] ? LFSR_TAPS : 16'h0);
	endfunction

	// show the pixel's color; rainbow reads the wheel and burns a count step
	function automatic void light_pixel(input int i);
		if (colour_of[i] == COLOUR_RAINBOW) begin
			shown_of[i] = wheel_rgbw(count_of[i]);
			count_of[i] = count_of[i] + 8'd1;
		end else if (colour_of[i] < COLOUR_RAINBOW) begin
			shown_of[i] = PALETTE[colour_of[i]];
		end
	endfunction

	function automatic void flash_pixel(input int i, input logic [7:0] lit_ticks,
			input logic [7:0] period_ticks);
		if (count_of[i] < lit_ticks) begin
			light_pixel(i);
		end else if (count_of[i] < period_ticks) begin
			shown_of[i] = DARK;
		end else begin
			count_of[i] = 8'd0;	// restart, color held
		end
	endfunction

	function automatic pixel_word_t make_word(input int i, input logic [31:0] rgbw);
		pixel_word_t word;
		word.px = i[4:0];
		{word.red, word.green, word.blue, word.white} = rgbw;
		word.last = (i == PIXELS - 1);
		return word;
	endfunction

	// apply one accepted input word; returns 1 when a frame goes out
	function automatic bit apply_effects(input logic o, input logic [4:0] px,
			input logic [3:0] cl, input logic [3:0] md);
		logic [31:0] prod;
		logic [7:0]  draw;
		if (o == OP_SET) begin
			if (px < PIXELS && cl <= COLOUR_RAINBOW && md <= MODE_MAX) begin
				if (mode_of[px] != md[2:0]) begin
					count_of[px] = 8'd0;
				end
				colour_of[px] = cl;
				mode_of[px]   = md[2:0];
			end
			return 1'b0;
		end
		for (int i = 0; i < PIXELS; i++) begin
			count_of[i] = count_of[i] + 8'd1;
			case (mode_of[i])
				MODE_OFF: begin
					shown_of[i] = DARK;
				end
				MODE_ON: begin
					light_pixel(i);
				end
				MODE_SLOW: begin
					flash_pixel(i, reg_file[REG_SLOW_ON][7:0], reg_file[REG_SLOW_END][7:0]);
				end
				MODE_FAST: begin
					flash_pixel(i, reg_file[REG_FAST_ON][7:0], reg_file[REG_FAST_END][7:0]);
				end
				MODE_RANDOM: begin
					// draw 0..254; a draw above the count flips a coin
					twinkle_step();
					prod = {16'd0, twinkle} * 32'd255;
					draw = prod[23:16];
					if (draw > count_of[i]) begin
						twinkle_step();
						if (twinkle[0] == 1'b0) begin
							light_pixel(i);
						end else begin
							shown_of[i] = DARK;
						end
					end
				end
				default: ;	// fade and breath hold the color
			endcase
			frame_buf[i] = make_word(i, shown_of[i]);
		end
		return 1'b1;
	endfunction

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// ------------------------------------------------------------------
	// Input side
	// ------------------------------------------------------------------
	// Offer one word after a random gap, hold it until taken, then log the
	// words it owes. A gap of zero keeps valid high across the two words.
	task automatic offer_word(input logic o, input logic [4:0] px, input logic [3:0] cl,
			input logic [3:0] md, input logic typed, input logic [PIXELS-1:0] lit_mask,
			input logic [31:0] lit_rgbw);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= o;
		pixel    <= px;
		colour   <= cl;
		mode     <= md;
		do @(posedge clk); while (in_stall);
		if (apply_effects(o, px, cl, md)) begin
			for (int i = 0; i < PIXELS; i++) begin
				if (typed) begin
					pending_pixels.push_back(make_word(i, lit_mask[i] ? lit_rgbw : DARK));
				end else begin
					pending_pixels.push_back(frame_buf[i]);
				end
			end
		end
	endtask

	// Random words: mostly ticks and legal sets, some junk sets. Junk that
	// the block just drops is not counted.
	task automatic run_random(input int words);
		int          done;
		int          pick;
		logic [31:0] rnd;
		logic        o;
		logic [4:0]  px;
		logic [3:0]  cl;
		logic [3:0]  md;
		done = 0;
		while (done < words) begin
			pick = $urandom_range(0, 99);
			rnd  = $urandom;
			px   = rnd[4:0];
			cl   = rnd[8:5];
			md   = rnd[12:9];
			o    = (pick < 55) ? OP_TICK : OP_SET;
			if (pick >= 55 && pick < 90) begin
				px = 5'($urandom_range(0, PIXELS - 1));
				cl = 4'($urandom_range(0, COLOUR_RAINBOW));
				md = 4'($urandom_range(0, MODE_MAX));
			end
			offer_word(o, px, cl, md, 1'b0, NO_PIXELS, DARK);
			if (o == OP_TICK || (px < PIXELS && cl <= COLOUR_RAINBOW && md <= MODE_MAX)) begin
				done++;
			end
		end
	endtask

	// Stop offering, let every owed word arrive, then give an in-flight
	// set (which owes nothing) time to finish.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// ------------------------------------------------------------------
	// Config port
	// ------------------------------------------------------------------
	// setup cycle, then access until pready; read data sampled at that edge
	task automatic apb_access(input logic wr, input logic [2:0] idx,
			input logic [31:0] data, output logic [31:0] rd);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_register(input logic [2:0] idx);
		logic [31:0] rd;
		apb_access(1'b0, idx, 32'd0, rd);
		check_field($sformatf("register %0d readback", idx), {16'd0, reg_file[idx]}, rd);
	endtask

	task automatic set_register(input logic [2:0] idx, input logic [31:0] value);
		logic [31:0] rd;
		apb_access(1'b1, idx, value, rd);
		store_register(idx, value);
		if (idx <= REG_SEED) begin
			check_register(idx);
		end
	endtask

	// ------------------------------------------------------------------
	// Output side: random stalls, one long hold on request, word check
	// ------------------------------------------------------------------
	initial begin : output_side
		int          hold;
		bit          holding;
		pixel_word_t want;
		out_stall <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			holding = hold_req;
			if (holding) begin
				hold = HOLD_CYCLES;
			end else begin
				hold = no_gaps ? 0 : $urandom_range(0, MAX_IDLE);
			end
			if (hold > 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
				out_stall <= 1'b0;
			end
			if (holding) begin
				hold_req = 1'b0;
			end
			do @(posedge clk); while (!out_valid);
			if (pending_pixels.size() == 0) begin
				$display("%0t ns: output word with none owed, expected nothing, actual pixel %0d",
					$time, out_pixel);
				mismatches++;
			end else begin
				want = pending_pixels.pop_front();
				check_field("out_pixel", want.px, out_pixel);
				check_field("red", want.red, red);
				check_field("green", want.green, green);
				check_field("blue", want.blue, blue);
				check_field("white", want.white, white);
				check_field("last", want.last, last);
			end
		end
	end

	// ------------------------------------------------------------------
	// Watchdog: too long with no word moving anywhere ends the run
	// ------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("led_pixel_effect_engine_unit regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		op       <= OP_SET;
		pixel    <= 5'd0;
		colour   <= COL_WARM_WHITE;
		mode     <= FX_OFF;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= 5'd0;
		pwdata   <= 32'd0;
		reset_effects();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// registers come up at their defaults
		for (int k = REG_FAST_ON; k <= REG_SEED; k++) begin
			check_register(3'(k));
		end

		// directed part, default flash timing
		for (int r = 0; r < DIRECTED_ROWS; r++) begin
			offer_word(SCRIPT[r].o, SCRIPT[r].px, SCRIPT[r].cl, SCRIPT[r].md,
				SCRIPT[r].typed, SCRIPT[r].lit_mask, SCRIPT[r].lit_rgbw);
		end
		wait_drained();

		// short flash periods so restarts happen often; write to a hole too
		set_register(REG_FAST_ON, 32'd2);
		set_register(REG_FAST_END, 32'd5);
		set_register(REG_SLOW_ON, 32'd3);
		set_register(REG_SLOW_END, 32'd9);
		set_register(REG_SEED, 32'h0000ACE1);
		set_register(REG_UNUSED, 32'h00001234);
		no_gaps = 1'b1;
		run_random(15);
		no_gaps = 1'b0;
		// long output stall while ticks keep coming: input must back up
		hold_req = 1'b1;
		run_random(20);
		wait_drained();

		// extremes: fast flash lit nearly all period, slow flash restarts at once
		set_register(REG_FAST_ON, 32'd255);
		set_register(REG_FAST_END, 32'd255);
		set_register(REG_SLOW_ON, 32'd1);
		set_register(REG_SLOW_END, 32'd1);
		set_register(REG_SEED, 32'h0000FFFF);
		run_random(15);
		// pause until the block has emptied out, then carry on
		wait_drained();
		run_random(15);
		wait_drained();

		// odd timing: fast never lit, slow end below slow on; zero seed loads as one
		set_register(REG_FAST_ON, 32'd0);
		set_register(REG_FAST_END, 32'd3);
		set_register(REG_SLOW_ON, 32'd6);
		set_register(REG_SLOW_END, 32'd2);
		set_register(REG_SEED, 32'd0);
		run_random(30);
		wait_drained();

		if (mismatches == 0) begin
			$display("led_pixel_effect_engine_unit regression: pass");
		end else begin
			$display("led_pixel_effect_engine_unit regression: fail");
		end
		$finish;
	end

endmodule

>>> led_pixel_effect_engine_unit.f
rtl/lpfx_pkg.sv
rtl/led_pixel_effect_engine_unit.sv
tb/led_pixel_effect_engine_unit_tb.sv
